// File: src/ffcu_pkg.sv
// ----------------------------------------------------------------------------
// ffcu_pkg
// Shared types, state codes and helpers for the forest fire cell update core.
// ----------------------------------------------------------------------------
package ffcu_pkg;

    // Cell state codes
    localparam logic [4:0] ST_EMPTY     = 5'd0;
    localparam logic [4:0] ST_SAPLING   = 5'd1;
    localparam logic [4:0] ST_TREE      = 5'd6;
    localparam logic [4:0] ST_SMOULDER  = 5'd7;
    localparam logic [4:0] ST_BURN_LO   = 5'd9;
    localparam logic [4:0] ST_BURN_HI   = 5'd17;
    localparam logic [4:0] ST_COLLAPSED = 5'd20;

    // Register map, indexed by paddr[3:2]
    localparam int          ADDR_W        = 4;
    localparam logic [1:0]  REG_SAPLING   = 2'd0;
    localparam logic [1:0]  REG_SPREAD    = 2'd1;
    localparam logic [1:0]  REG_IGNITE    = 2'd2;
    localparam logic [1:0]  REG_SEED      = 2'd3;

    // Register reset values
    localparam logic [31:0] SAPLING_RST   = 32'd12885;
    localparam logic [31:0] SPREAD_RST    = 32'd21474837;
    localparam logic [31:0] IGNITE_RST    = 32'd107375;
    localparam logic [31:0] SEED_RST      = 32'd1;

    // Grid defaults
    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 64;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Classified cell, front to back
    typedef struct packed {
        logic [4:0]  own;
        logic        any_tree;
        logic        any_burn;
        logic        plant_hit;
        logic        ignite_hit;
        logic [31:0] word;
    } entry_t;

    // Register contents and seed load strobe
    typedef struct packed {
        logic [31:0] sapling_thr;
        logic [31:0] spread_thr;
        logic [31:0] ignite_thr;
        logic        seed_load;
        logic [31:0] seed_val;
    } cfg_t;

    // One xorshift step: 13 left, 17 right, 5 left
    function automatic logic [31:0] xorshift32(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction

    function automatic logic is_burning(input logic [4:0] s);
        return (s >= ST_BURN_LO) && (s <= ST_BURN_HI);
    endfunction

endpackage

// File: src/ffcu_regs.sv
// ----------------------------------------------------------------------------
// ffcu_regs
// APB register file: thresholds and generator seed.
// ----------------------------------------------------------------------------
module ffcu_regs (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffcu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output ffcu_pkg::cfg_t               cfg
);
    import ffcu_pkg::*;

    logic [31:0] sapling_reg;
    logic [31:0] spread_reg;
    logic [31:0] ignite_reg;
    logic [31:0] seed_reg;
    logic        wr_en;
    logic [1:0]  idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    // Write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sapling_reg   <= SAPLING_RST;
            spread_reg    <= SPREAD_RST;
            ignite_reg    <= IGNITE_RST;
            seed_reg      <= SEED_RST;
        end else begin
            if (wr_en) begin
                case (idx)
                    REG_SAPLING: sapling_reg <= pwdata;
                    REG_SPREAD:  spread_reg  <= pwdata;
                    REG_IGNITE:  ignite_reg  <= pwdata;
                    REG_SEED:    seed_reg    <= pwdata;
                    default: ;
                endcase
            end
        end
    end

    // Read back
    always_comb begin
        case (idx)
            REG_SAPLING: prdata = sapling_reg;
            REG_SPREAD:  prdata = spread_reg;
            REG_IGNITE:  prdata = ignite_reg;
            REG_SEED:    prdata = seed_reg;
            default:     prdata = '0;
        endcase
    end

    // Seed strobe and value go out on the access edge so the generator
    // reloads at the same edge as the register
    assign cfg.sapling_thr = sapling_reg;
    assign cfg.spread_thr  = spread_reg;
    assign cfg.ignite_thr  = ignite_reg;
    assign cfg.seed_load   = wr_en && (idx == REG_SEED);
    assign cfg.seed_val    = pwdata;

endmodule

// File: src/ffcu_front.sv
// ----------------------------------------------------------------------------
// ffcu_front
// Accepts cells, steps the xorshift generator and classifies the neighbourhood.
// ----------------------------------------------------------------------------
module ffcu_front #(
    parameter int GRID_WIDTH  = ffcu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ffcu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ffcu_pkg::cfg_t      cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [4:0]          s_own_cell,
    input  logic [4:0]          s_west_cell,
    input  logic [4:0]          s_east_cell,
    input  logic [4:0]          s_north_cell,
    input  logic [4:0]          s_south_cell,
    input  logic [7:0]          s_cell_col,
    input  logic [5:0]          s_cell_row,
    input  logic signed [8:0]   s_pointer_col,
    input  logic signed [6:0]   s_pointer_row,
    input  logic                s_plant_held,
    input  logic                s_ignite_held,
    output logic                push,
    output ffcu_pkg::entry_t    push_entry,
    input  logic                q_full
);
    import ffcu_pkg::*;

    logic [31:0] rng_reg;
    logic [31:0] rng_next;
    logic        col_hit;
    logic        row_hit;
    logic        hit;

    assign s_ready  = !q_full;
    assign push     = s_valid && s_ready;
    assign rng_next = xorshift32(rng_reg);

    // Pointer hit: non-negative, equal, and inside the grid
    assign col_hit = !s_pointer_col[8] && (s_pointer_col[7:0] == s_cell_col)
                     && ({24'd0, s_cell_col} < 32'(GRID_WIDTH));
    assign row_hit = !s_pointer_row[6] && (s_pointer_row[5:0] == s_cell_row)
                     && ({26'd0, s_cell_row} < 32'(GRID_HEIGHT));
    assign hit     = col_hit && row_hit;

    // Classify the neighbourhood
    always_comb begin
        push_entry.own        = s_own_cell;
        push_entry.any_tree   = (s_west_cell == ST_TREE) || (s_east_cell == ST_TREE)
                                || (s_north_cell == ST_TREE) || (s_south_cell == ST_TREE);
        push_entry.any_burn   = is_burning(s_west_cell) || is_burning(s_east_cell)
                                || is_burning(s_north_cell) || is_burning(s_south_cell);
        push_entry.plant_hit  = s_plant_held && hit;
        push_entry.ignite_hit = s_ignite_held && hit;
        push_entry.word       = rng_next;
    end

    // Advance the generator once per beat; reload on a seed write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rng_reg <= SEED_RST | 32'd1;
        end else if (cfg.seed_load) begin
            rng_reg <= cfg.seed_val | 32'd1;
        end else if (push) begin
            rng_reg <= rng_next;
        end
    end

endmodule

// File: src/ffcu_queue.sv
// ----------------------------------------------------------------------------
// ffcu_queue
// Short FIFO between front and back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ffcu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ffcu_pkg::entry_t  push_entry,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output ffcu_pkg::entry_t  head
);
    import ffcu_pkg::*;

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = slot_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: src/ffcu_back.sv
// ----------------------------------------------------------------------------
// ffcu_back
// Compares the random word against thresholds, or steps a smouldering or burning cell on, and registers the new state.
// ----------------------------------------------------------------------------
module ffcu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  ffcu_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  ffcu_pkg::entry_t  head,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [4:0]        m_new_cell
);
    import ffcu_pkg::*;

    logic        valid_reg;
    logic [4:0]  cell_reg;
    logic [4:0]  cell_next;
    logic [31:0] grow_thr;

    assign pop      = q_valid && (!valid_reg || m_ready);
    assign grow_thr = head.any_tree ? cfg.spread_thr : cfg.sapling_thr;

    // Next state of the cell
    always_comb begin
        if (head.own == ST_EMPTY) begin
            cell_next = ((head.word < grow_thr) || head.plant_hit) ? ST_SAPLING : ST_EMPTY;
        end else if (head.own == ST_TREE) begin
            cell_next = (head.any_burn || (head.word < cfg.ignite_thr) || head.ignite_hit)
                        ? ST_SMOULDER : ST_TREE;
        end else if (head.own < ST_COLLAPSED) begin
            cell_next = head.own + 5'd1;
        end else begin
            cell_next = ST_EMPTY;
        end
    end

    // Output register: load on pop, drop once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cell_reg <= cell_next;
        end
    end

    assign m_valid    = valid_reg;
    assign m_new_cell = cell_reg;

endmodule

// File: src/forest_fire_cell_update_core.sv
// ----------------------------------------------------------------------------
// forest_fire_cell_update_core
// Next-state logic for one cell of a forest fire cellular automaton.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one cell per beat: its old state, the four neighbour
//   states (empty for neighbours outside the grid), its coordinates, the
//   pointer position and the plant and ignite flags. The m_ channel returns
//   one new cell state per beat, in order.
//   Every accepted beat advances a 32-bit xorshift generator once.
//   m_valid rises once a beat accepted on s_ has passed through a queue slot
//   and the output register; throughput is one cell per cycle while the
//   queue has room, set by the single generator step in the front stage. A
//   2-entry queue separates the front from the output register.
//   When the receiver stalls, the output register holds and the queue fills;
//   s_ready falls once the queue is full, so two further beats are taken.
//   The APB port writes thresholds and the seed; a seed write reloads the
//   generator with the seed, bit zero forced high.
//   Synchronous reset empties the queue and output register, restores the
//   register defaults and loads the generator with one.
// ----------------------------------------------------------------------------
module forest_fire_cell_update_core #(
    parameter int GRID_WIDTH  = ffcu_pkg::GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = ffcu_pkg::GRID_HEIGHT_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffcu_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [4:0]                   s_own_cell,
    input  logic [4:0]                   s_west_cell,
    input  logic [4:0]                   s_east_cell,
    input  logic [4:0]                   s_north_cell,
    input  logic [4:0]                   s_south_cell,
    input  logic [7:0]                   s_cell_col,
    input  logic [5:0]                   s_cell_row,
    input  logic signed [8:0]            s_pointer_col,
    input  logic signed [6:0]            s_pointer_row,
    input  logic                         s_plant_held,
    input  logic                         s_ignite_held,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [4:0]                   m_new_cell
);
    import ffcu_pkg::*;

    cfg_t   cfg;
    entry_t push_entry;
    entry_t head;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;

    ffcu_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ffcu_front #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_own_cell    (s_own_cell),
        .s_west_cell   (s_west_cell),
        .s_east_cell   (s_east_cell),
        .s_north_cell  (s_north_cell),
        .s_south_cell  (s_south_cell),
        .s_cell_col    (s_cell_col),
        .s_cell_row    (s_cell_row),
        .s_pointer_col (s_pointer_col),
        .s_pointer_row (s_pointer_row),
        .s_plant_held  (s_plant_held),
        .s_ignite_held (s_ignite_held),
        .push          (push),
        .push_entry    (push_entry),
        .q_full        (q_full)
    );

    ffcu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .head       (head)
    );

    ffcu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_new_cell (m_new_cell)
    );

endmodule

// File: src/ffcu_checker.sv
// ----------------------------------------------------------------------------
// ffcu_checker
// Port-level assertions for the forest fire cell update core.
// ----------------------------------------------------------------------------
module ffcu_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        pready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [4:0]  m_new_cell
);
    import ffcu_pkg::*;

    // Reset empties the output side
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // Results stay within the state encoding
    a_state_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_new_cell <= ST_COLLAPSED))
        else $error("new cell state out of range");

    // Hold a stalled result
    a_hold_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_new_cell)))
        else $error("stalled result dropped or changed");

    // Register port never inserts wait states
    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind forest_fire_cell_update_core ffcu_checker u_ffcu_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .pready     (pready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_new_cell (m_new_cell)
);
